// ===== design/lhbt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhbt_pkg
// Shared types and constants for the link health and backoff tracker.
// ----------------------------------------------------------------------------
package lhbt_pkg;

  typedef enum logic [1:0] {
    MODE_DISCONNECTED = 2'd0,
    MODE_CONNECTED    = 2'd1,
    MODE_DEGRADED     = 2'd2
  } link_mode_t;

  typedef enum logic [1:0] {
    REQ_QUERY    = 2'd0,
    REQ_START    = 2'd1,
    REQ_COMPLETE = 2'd2,
    REQ_LINK_UP  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    CFG_MAX_INFLIGHT  = 2'd0,
    CFG_MIN_BACKOFF   = 2'd1,
    CFG_MAX_BACKOFF   = 2'd2,
    CFG_DEG_THRESHOLD = 2'd3
  } cfg_index_t;

  localparam logic [15:0] RST_MAX_INFLIGHT  = 16'd100;
  localparam logic [15:0] RST_MIN_BACKOFF   = 16'd100;
  localparam logic [15:0] RST_MAX_BACKOFF   = 16'd30000;
  localparam logic [7:0]  RST_DEG_THRESHOLD = 8'd3;

endpackage

// ===== design/link_health_backoff_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_health_backoff_tracker
// Link state, in-flight and error counters with capped exponential backoff.
// ----------------------------------------------------------------------------
// pipeline: input accept into the input reg, then the result reg to result accept
// throughput: one item per cycle unless out_stall holds the result; state update
//   is a single pass of adders, one 17-bit shift with compare and the mode logic
// reset: synchronous active-low rst_n clears both stages, sets link to
//   disconnected, clears the counters and loads the default registers
module link_health_backoff_tracker (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  // events
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic        in_success,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_link_state,
  output logic        out_can_accept,
  output logic [15:0] out_backoff_ms,
  output logic [15:0] out_inflight,
  output logic [31:0] out_error_count
);

  // configuration registers
  logic [15:0] max_inflight_r;
  logic [15:0] min_backoff_r;
  logic [15:0] max_backoff_r;
  logic [7:0]  deg_threshold_r;

  // tracker state
  lhbt_pkg::link_mode_t mode_r, mode_nxt;
  logic [15:0] inflight_r, inflight_nxt;
  logic [7:0]  err_run_r, err_run_nxt;
  logic [31:0] err_total_r, err_total_nxt;
  logic [15:0] backoff_r, backoff_nxt;

  // input stage
  logic                  s1_vld_r;
  lhbt_pkg::req_type_t   s1_type_r;
  logic                  s1_success_r;

  // result stage
  logic        out_vld_r;
  logic [1:0]  out_state_r;
  logic        out_accept_r;
  logic [15:0] out_backoff_r;
  logic [15:0] out_inflight_r;
  logic [31:0] out_errors_r;

  logic        out_ready;
  logic        s1_adv;
  logic        in_take;
  logic [16:0] doubled;
  logic        can_accept_nxt;
  logic [15:0] cfg_nz;

  assign out_ready = !out_vld_r || !out_stall;
  assign s1_adv    = s1_vld_r && out_ready;
  assign in_stall  = s1_vld_r && !out_ready;
  assign in_take   = in_valid && !in_stall;

  // a zero write to the 16-bit registers falls back to the reset value
  always_comb begin
    cfg_nz = cfg_wdata;
    case (lhbt_pkg::cfg_index_t'(cfg_addr))
      lhbt_pkg::CFG_MAX_INFLIGHT:
        if (cfg_wdata == 16'd0) cfg_nz = lhbt_pkg::RST_MAX_INFLIGHT;
      lhbt_pkg::CFG_MIN_BACKOFF:
        if (cfg_wdata == 16'd0) cfg_nz = lhbt_pkg::RST_MIN_BACKOFF;
      lhbt_pkg::CFG_MAX_BACKOFF:
        if (cfg_wdata == 16'd0) cfg_nz = lhbt_pkg::RST_MAX_BACKOFF;
      default: cfg_nz = cfg_wdata;
    endcase
  end

  always_comb begin
    mode_nxt      = mode_r;
    inflight_nxt  = inflight_r;
    err_run_nxt   = err_run_r;
    err_total_nxt = err_total_r;
    backoff_nxt   = backoff_r;
    doubled       = {backoff_r, 1'b0};
    case (s1_type_r)
      lhbt_pkg::REQ_START: begin
        if (inflight_r != 16'hFFFF) inflight_nxt = inflight_r + 16'd1;
      end
      lhbt_pkg::REQ_COMPLETE: begin
        if (inflight_r != 16'd0) inflight_nxt = inflight_r - 16'd1;
        if (s1_success_r) begin
          err_run_nxt = 8'd0;
          if (mode_r == lhbt_pkg::MODE_DEGRADED) begin
            mode_nxt    = lhbt_pkg::MODE_CONNECTED;
            backoff_nxt = min_backoff_r;
          end
        end else begin
          if (err_run_r != 8'hFF) err_run_nxt = err_run_r + 8'd1;
          if (err_total_r != 32'hFFFF_FFFF) err_total_nxt = err_total_r + 32'd1;
          // threshold compares against the run after this failure
          if (err_run_nxt >= deg_threshold_r && mode_r == lhbt_pkg::MODE_CONNECTED)
            mode_nxt = lhbt_pkg::MODE_DEGRADED;
          if (doubled > {1'b0, max_backoff_r}) backoff_nxt = max_backoff_r;
          else backoff_nxt = doubled[15:0];
        end
      end
      lhbt_pkg::REQ_LINK_UP: begin
        mode_nxt    = lhbt_pkg::MODE_CONNECTED;
        err_run_nxt = 8'd0;
        backoff_nxt = min_backoff_r;
      end
      default: ;
    endcase
    can_accept_nxt = (inflight_nxt < max_inflight_r) &&
                     (mode_nxt == lhbt_pkg::MODE_CONNECTED ||
                      mode_nxt == lhbt_pkg::MODE_DEGRADED);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_inflight_r  <= lhbt_pkg::RST_MAX_INFLIGHT;
      min_backoff_r   <= lhbt_pkg::RST_MIN_BACKOFF;
      max_backoff_r   <= lhbt_pkg::RST_MAX_BACKOFF;
      deg_threshold_r <= lhbt_pkg::RST_DEG_THRESHOLD;
      mode_r          <= lhbt_pkg::MODE_DISCONNECTED;
      inflight_r      <= 16'd0;
      err_run_r       <= 8'd0;
      err_total_r     <= 32'd0;
      backoff_r       <= lhbt_pkg::RST_MIN_BACKOFF;
      s1_vld_r        <= 1'b0;
      out_vld_r       <= 1'b0;
    end else begin
      if (s1_adv) begin
        mode_r      <= mode_nxt;
        inflight_r  <= inflight_nxt;
        err_run_r   <= err_run_nxt;
        err_total_r <= err_total_nxt;
        backoff_r   <= backoff_nxt;
      end
      if (cfg_we) begin
        case (lhbt_pkg::cfg_index_t'(cfg_addr))
          lhbt_pkg::CFG_MAX_INFLIGHT: max_inflight_r <= cfg_nz;
          lhbt_pkg::CFG_MIN_BACKOFF: begin
            min_backoff_r <= cfg_nz;
            backoff_r     <= cfg_nz;
          end
          lhbt_pkg::CFG_MAX_BACKOFF:   max_backoff_r   <= cfg_nz;
          lhbt_pkg::CFG_DEG_THRESHOLD: deg_threshold_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_take) s1_vld_r <= 1'b1;
      else if (s1_adv) s1_vld_r <= 1'b0;
      if (s1_adv) out_vld_r <= 1'b1;
      else if (!out_stall) out_vld_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_type_r    <= lhbt_pkg::req_type_t'(in_req_type);
      s1_success_r <= in_success;
    end
    if (s1_adv) begin
      out_state_r    <= mode_nxt;
      out_accept_r   <= can_accept_nxt;
      out_backoff_r  <= backoff_nxt;
      out_inflight_r <= inflight_nxt;
      out_errors_r   <= err_total_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_link_state   = out_state_r;
  assign out_can_accept   = out_accept_r;
  assign out_backoff_ms   = out_backoff_r;
  assign out_inflight     = out_inflight_r;
  assign out_error_count  = out_errors_r;

endmodule

// ===== design/lhbt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhbt_checker
// Port-level checks for the link health tracker, bound to the top level.
// ----------------------------------------------------------------------------
module lhbt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_link_state,
  input logic        out_can_accept,
  input logic [15:0] out_backoff_ms,
  input logic [15:0] out_inflight,
  input logic [31:0] out_error_count
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_link_state) &&
      $stable(out_can_accept) && $stable(out_backoff_ms) && $stable(out_inflight) &&
      $stable(out_error_count))
    else $error("result changed while stalled");

  // a disconnected link never reports room for requests
  a_disc_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_link_state == lhbt_pkg::MODE_DISCONNECTED |-> !out_can_accept)
    else $error("can_accept while disconnected");

  // can_accept needs inflight below a 16-bit limit
  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_can_accept |-> out_inflight != 16'hFFFF)
    else $error("can_accept with saturated inflight");

  // backoff never drops to zero
  a_backoff_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_backoff_ms != 16'd0)
    else $error("zero backoff");

  // reset empties the result stage
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind link_health_backoff_tracker lhbt_checker u_lhbt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_link_state   (out_link_state),
  .out_can_accept   (out_can_accept),
  .out_backoff_ms   (out_backoff_ms),
  .out_inflight     (out_inflight),
  .out_error_count  (out_error_count)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the link health and backoff tracker. Events go in
// through the valid/stall input channel. A behavioral tracker predicts the
// status item that each accepted event produces. A checker compares every
// result with the oldest prediction. Directed tests, register corners, a
// long receiver hold-off, random traffic and counter limit runs are covered.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    lhbt_pkg::link_mode_t link_state;
    logic        can_accept;
    logic [15:0] backoff_ms;
    logic [15:0] inflight;
    logic [31:0] error_count;
  } link_status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = 2'd0;
  logic [15:0] cfg_wdata = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = 2'd0;
  logic        in_success = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_link_state;
  logic        out_can_accept;
  logic [15:0] out_backoff_ms;
  logic [15:0] out_inflight;
  logic [31:0] out_error_count;

  // tracker copy of the block state and registers
  lhbt_pkg::link_mode_t trk_mode = lhbt_pkg::MODE_DISCONNECTED;
  logic [15:0] trk_inflight = 16'd0;
  logic [7:0]  trk_err_run = 8'd0;
  logic [31:0] trk_err_total = 32'd0;
  logic [15:0] trk_backoff = lhbt_pkg::RST_MIN_BACKOFF;
  logic [15:0] reg_max_inflight = lhbt_pkg::RST_MAX_INFLIGHT;
  logic [15:0] reg_min_backoff = lhbt_pkg::RST_MIN_BACKOFF;
  logic [15:0] reg_max_backoff = lhbt_pkg::RST_MAX_BACKOFF;
  logic [7:0]  reg_threshold = lhbt_pkg::RST_DEG_THRESHOLD;

  link_status_t pending_status[$];
  int mismatches = 0;
  int send_idle_pct = 35;
  int recv_idle_pct = 53;
  int hold_left = 0;
  int quiet_cycles = 0;

  link_health_backoff_tracker dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_success       (in_success),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_link_state   (out_link_state),
    .out_can_accept   (out_can_accept),
    .out_backoff_ms   (out_backoff_ms),
    .out_inflight     (out_inflight),
    .out_error_count  (out_error_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic link_status_t track_event(input lhbt_pkg::req_type_t kind,
                                               input logic ok);
    link_status_t st;
    logic [16:0] doubled;
    case (kind)
      lhbt_pkg::REQ_START: begin
        if (trk_inflight != 16'hFFFF) trk_inflight = trk_inflight + 16'd1;
      end
      lhbt_pkg::REQ_COMPLETE: begin
        if (trk_inflight != 16'd0) trk_inflight = trk_inflight - 16'd1;
        if (ok) begin
          trk_err_run = 8'd0;
          if (trk_mode == lhbt_pkg::MODE_DEGRADED) begin
            trk_mode = lhbt_pkg::MODE_CONNECTED;
            trk_backoff = reg_min_backoff;
          end
        end else begin
          if (trk_err_run != 8'hFF) trk_err_run = trk_err_run + 8'd1;
          if (trk_err_total != 32'hFFFF_FFFF) trk_err_total = trk_err_total + 32'd1;
          if (trk_err_run >= reg_threshold && trk_mode == lhbt_pkg::MODE_CONNECTED) begin
            trk_mode = lhbt_pkg::MODE_DEGRADED;
          end
          doubled = {trk_backoff, 1'b0};
          trk_backoff = (doubled > {1'b0, reg_max_backoff}) ? reg_max_backoff : doubled[15:0];
        end
      end
      lhbt_pkg::REQ_LINK_UP: begin
        trk_mode = lhbt_pkg::MODE_CONNECTED;
        trk_err_run = 8'd0;
        trk_backoff = reg_min_backoff;
      end
      default: ;
    endcase
    st.link_state = trk_mode;
    st.can_accept = (trk_inflight < reg_max_inflight) &&
                    (trk_mode == lhbt_pkg::MODE_CONNECTED ||
                     trk_mode == lhbt_pkg::MODE_DEGRADED);
    st.backoff_ms = trk_backoff;
    st.inflight = trk_inflight;
    st.error_count = trk_err_total;
    return st;
  endfunction

  task automatic report_mismatch(input string what, input link_status_t want,
                                 input link_status_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch (%s): expected state %0d accept %0b backoff %0d",
               $realtime, what, want.link_state, want.can_accept, want.backoff_ms);
      $display("%0t   expected inflight %0d errors %0d",
               $realtime, want.inflight, want.error_count);
      $display("%0t   got state %0d accept %0b backoff %0d inflight %0d errors %0d",
               $realtime, seen.link_state, seen.can_accept, seen.backoff_ms,
               seen.inflight, seen.error_count);
    end
  endtask

  // result checker and receiver stall generator
  always @(posedge clk) begin : check_status
    link_status_t want;
    link_status_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.link_state = lhbt_pkg::link_mode_t'(out_link_state);
      seen.can_accept = out_can_accept;
      seen.backoff_ms = out_backoff_ms;
      seen.inflight = out_inflight;
      seen.error_count = out_error_count;
      if (pending_status.size() == 0) begin
        report_mismatch("no item expected", '0, seen);
      end else begin
        want = pending_status.pop_front();
        if (seen.link_state !== want.link_state || seen.can_accept !== want.can_accept ||
            seen.backoff_ms !== want.backoff_ms || seen.inflight !== want.inflight ||
            seen.error_count !== want.error_count) begin
          report_mismatch("status fields", want, seen);
        end
      end
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_event(input lhbt_pkg::req_type_t kind, input logic ok);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid    <= 1'b0;
      in_req_type <= 2'($urandom);
      in_success  <= 1'($urandom);
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_success  <= ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_status.push_back(track_event(kind, ok));
  endtask

  task automatic send_random_event();
    int roll;
    roll = $urandom_range(99);
    if (roll < 6) send_event(lhbt_pkg::REQ_LINK_UP, 1'($urandom));
    else if (roll < 14) send_event(lhbt_pkg::REQ_QUERY, 1'($urandom));
    else if (roll < 54) send_event(lhbt_pkg::REQ_START, 1'($urandom));
    else send_event(lhbt_pkg::REQ_COMPLETE, $urandom_range(99) < 55);
  endtask

  // always waits on the clock before checking so back to back calls stay clean
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  task automatic write_config(input logic [15:0] lim, input logic [15:0] lo,
                              input logic [15:0] hi, input logic [15:0] thr);
    logic [15:0] vals [4];
    lhbt_pkg::cfg_index_t idx;
    wait_for_results();
    vals = '{lim, lo, hi, thr};
    for (int i = 0; i < 4; i++) begin
      idx = lhbt_pkg::cfg_index_t'(i);
      cfg_we    <= 1'b1;
      cfg_addr  <= idx;
      cfg_wdata <= vals[i];
      @(posedge clk);
      // zero on a limit register falls back to its default
      case (idx)
        lhbt_pkg::CFG_MAX_INFLIGHT:
          reg_max_inflight = (vals[i] == 16'd0) ? lhbt_pkg::RST_MAX_INFLIGHT : vals[i];
        lhbt_pkg::CFG_MIN_BACKOFF: begin
          reg_min_backoff = (vals[i] == 16'd0) ? lhbt_pkg::RST_MIN_BACKOFF : vals[i];
          trk_backoff = reg_min_backoff;
        end
        lhbt_pkg::CFG_MAX_BACKOFF:
          reg_max_backoff = (vals[i] == 16'd0) ? lhbt_pkg::RST_MAX_BACKOFF : vals[i];
        lhbt_pkg::CFG_DEG_THRESHOLD: reg_threshold = vals[i][7:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd1;
      3: return 16'($urandom_range(8, 1));
      4: return 16'($urandom_range(600, 2));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_threshold();
    logic [7:0] thr;
    case ($urandom_range(3))
      0: thr = 8'd0;
      1: thr = 8'hFF;
      2: thr = 8'($urandom);
      default: thr = 8'($urandom_range(6, 1));
    endcase
    return {8'($urandom), thr};
  endfunction

  task automatic test_basic_events();
    send_event(lhbt_pkg::REQ_QUERY, 1'b1);
    send_event(lhbt_pkg::REQ_START, 1'b1);     // counts even while refused
    send_event(lhbt_pkg::REQ_COMPLETE, 1'b0);  // failure while disconnected
    send_event(lhbt_pkg::REQ_COMPLETE, 1'b0);  // nothing in flight
    send_event(lhbt_pkg::REQ_LINK_UP, 1'b0);
    send_event(lhbt_pkg::REQ_START, 1'b0);
    send_event(lhbt_pkg::REQ_START, 1'b1);
    send_event(lhbt_pkg::REQ_COMPLETE, 1'b1);
    send_event(lhbt_pkg::REQ_COMPLETE, 1'b0);
    send_event(lhbt_pkg::REQ_COMPLETE, 1'b0);
    send_event(lhbt_pkg::REQ_COMPLETE, 1'b0);  // third error degrades
    send_event(lhbt_pkg::REQ_QUERY, 1'b0);
    send_event(lhbt_pkg::REQ_COMPLETE, 1'b1);  // recovery reloads minimum
    send_event(lhbt_pkg::REQ_LINK_UP, 1'b1);
  endtask

  task automatic test_register_corners();
    // all zero: limits fall back to defaults, threshold zero is kept
    write_config(16'd0, 16'd0, 16'd0, 16'h1200);
    send_event(lhbt_pkg::REQ_LINK_UP, 1'b0);
    send_event(lhbt_pkg::REQ_COMPLETE, 1'b0);
    // minimum above maximum
    write_config(16'd1, 16'hFFFF, 16'd1, 16'h00FF);
    send_event(lhbt_pkg::REQ_LINK_UP, 1'b1);
    send_event(lhbt_pkg::REQ_START, 1'b0);
    send_event(lhbt_pkg::REQ_COMPLETE, 1'b0);
    send_event(lhbt_pkg::REQ_COMPLETE, 1'b1);
    write_config(16'hFFFF, 16'd1, 16'hFFFF, 16'hED01);
    send_event(lhbt_pkg::REQ_LINK_UP, 1'b0);
    send_event(lhbt_pkg::REQ_COMPLETE, 1'b0);
    send_event(lhbt_pkg::REQ_COMPLETE, 1'b1);
  endtask

  task automatic test_backpressure();
    write_config(16'd100, 16'd100, 16'd30000, 16'd3);
    hold_left = 300;
    repeat (30) send_random_event();
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 4) begin
        send_idle_pct = 53;
        recv_idle_pct = 35;
      end else if (phase == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: write_config(16'd1, 16'd1, 16'hFFFF, 16'h0000);
        1: write_config(16'hFFFF, 16'hFFFF, 16'd1, 16'hA5FF);
        2: write_config(16'd0, 16'd0, 16'd0, 16'h5A01);
        3: write_config(16'd2, 16'd3, 16'd200, 16'h0002);
        default: write_config(pick_limit(), pick_limit(), pick_limit(), pick_threshold());
      endcase
      repeat (55) send_random_event();
    end
  endtask

  task automatic test_error_run_limit();
    write_config(16'd100, 16'd1, 16'hFFFF, 16'h00FF);
    send_event(lhbt_pkg::REQ_LINK_UP, 1'b0);
    repeat (260) send_event(lhbt_pkg::REQ_COMPLETE, 1'b0);
    send_event(lhbt_pkg::REQ_COMPLETE, 1'b1);
    send_event(lhbt_pkg::REQ_QUERY, 1'b1);
  endtask

  // starts run past the in-flight limit, then extra completions drain it to zero
  task automatic test_inflight_limit();
    write_config(16'd20, 16'd100, 16'd30000, 16'd3);
    send_event(lhbt_pkg::REQ_LINK_UP, 1'b1);
    repeat (30) send_event(lhbt_pkg::REQ_START, 1'($urandom));
    repeat (32) send_event(lhbt_pkg::REQ_COMPLETE, $urandom_range(7) != 0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_events();
    test_register_corners();
    test_backpressure();
    test_random_traffic();
    test_error_run_limit();
    test_inflight_limit();
    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
